// File: rtl/cpcr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpcr_pkg
// Shared types, constants and helpers of the prefix colour-count row block.
// ----------------------------------------------------------------------------
package cpcr_pkg;

    localparam int MAX_COLORS = 15;
    localparam int MAX_PAIRS  = 4;
    localparam int MAX_POINTS = 65536;

    localparam int COLOR_W = 4;
    localparam int CNT_W   = 17;
    localparam int DIM_W   = 4;
    localparam int VALUE_W = 52;
    localparam int WGT_W   = 16;
    localparam int PAIR_W  = 2;
    localparam int NPAIR_W = 3;
    localparam int PROD_W  = WGT_W + CNT_W;
    localparam int PBD_W   = PROD_W + WGT_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;

    localparam logic [COLOR_W-1:0] COLOR_NONE = 4'hF;

    localparam logic [1:0] KIND_DIFF   = 2'd0;
    localparam logic [1:0] KIND_RAT_LO = 2'd1;
    localparam logic [1:0] KIND_RAT_HI = 2'd2;
    localparam logic [1:0] KIND_POS    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_PAIR_COUNTS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIFF_COLORS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIFF_WEIGHTS_A  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIFF_WEIGHTS_B  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO_COLORS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO_WEIGHTS_A = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO_WEIGHTS_B = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO_DELTAS    = 3'd7;

    typedef struct packed {
        logic               clr;
        logic               cnt;
        logic [COLOR_W-1:0] color;
    } t_cmd;

    typedef struct packed {
        logic [6:0]  pair_counts;
        logic [31:0] diff_colors;
        logic [63:0] diff_weights_a;
        logic [63:0] diff_weights_b;
        logic [31:0] ratio_colors;
        logic [63:0] ratio_weights_a;
        logic [63:0] ratio_weights_b;
        logic [63:0] ratio_deltas;
    } t_cfg;

    function automatic logic color_counted(input logic [COLOR_W-1:0] c,
                                           input int unsigned max_colors);
        color_counted = (c != COLOR_NONE) && ({28'd0, c} < max_colors);
    endfunction

endpackage
`default_nettype wire

// File: rtl/cpcr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpcr_front
// Accepts point items and turns each into queue commands: a start item
// becomes a clear command followed by a point command.
// ----------------------------------------------------------------------------
module cpcr_front #(
    parameter int MAX_COLORS = cpcr_pkg::MAX_COLORS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [cpcr_pkg::COLOR_W-1:0] i_color,
    input  wire logic                         i_start,
    input  wire logic                         i_full,
    output logic                              o_push,
    output cpcr_pkg::t_cmd                    o_cmd
);

    logic           r_pend;
    logic           n_pend;
    cpcr_pkg::t_cmd r_pend_cmd;
    cpcr_pkg::t_cmd pt_cmd;
    logic           accept;

    assign o_ready = !r_pend && !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        pt_cmd.clr   = 1'b0;
        pt_cmd.cnt   = cpcr_pkg::color_counted(i_color, MAX_COLORS);
        pt_cmd.color = i_color;
    end

    always_comb begin
        o_push = 1'b0;
        o_cmd  = pt_cmd;
        n_pend = r_pend;
        if (r_pend) begin
            o_push = !i_full;
            o_cmd  = r_pend_cmd;
            if (!i_full) begin
                n_pend = 1'b0;
            end
        end else if (accept) begin
            o_push = 1'b1;
            if (i_start) begin
                o_cmd.clr = 1'b1;
                o_cmd.cnt = 1'b0;
                n_pend    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend_cmd <= pt_cmd;
        end
    end

endmodule
`default_nettype wire

// File: rtl/cpcr_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpcr_queue
// Short command queue between the front and the row engine.
// ----------------------------------------------------------------------------
module cpcr_queue (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire cpcr_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  wire logic     i_pop,
    output logic          o_valid,
    output cpcr_pkg::t_cmd o_cmd
);

    cpcr_pkg::t_cmd                 r_slot [cpcr_pkg::QDEPTH];
    logic [cpcr_pkg::QPTR_W-1:0]    r_wr;
    logic [cpcr_pkg::QPTR_W-1:0]    r_rd;
    logic [cpcr_pkg::QCNT_W-1:0]    r_cnt;
    logic                           do_push;
    logic                           do_pop;

    assign o_full  = (r_cnt == cpcr_pkg::QCNT_W'(cpcr_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_slot[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_cmd;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= cpcr_pkg::QCNT_W'(cpcr_pkg::QDEPTH))
        else $error("queue fill above depth");

endmodule
`default_nettype wire

// File: rtl/cpcr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpcr_back
// Row engine: applies commands to the colour counts and position, then issues
// one row dimension a cycle, unless stalled, into the shared multiplier pipeline.
// ----------------------------------------------------------------------------
module cpcr_back #(
    parameter int MAX_COLORS = cpcr_pkg::MAX_COLORS,
    parameter int MAX_POINTS = cpcr_pkg::MAX_POINTS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire cpcr_pkg::t_cfg               i_cfg,
    input  wire logic                         i_q_valid,
    input  wire cpcr_pkg::t_cmd               i_q_cmd,
    output logic                              o_q_pop,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [cpcr_pkg::CNT_W-1:0]        o_out_row,
    output logic [cpcr_pkg::DIM_W-1:0]        o_out_dim,
    output logic signed [cpcr_pkg::VALUE_W-1:0] o_out_value,
    output logic                              o_out_last
);

    localparam int CIDX_W = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
    localparam int CNT_W  = cpcr_pkg::CNT_W;
    localparam int VAL_W  = cpcr_pkg::VALUE_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_UPD  = 2'd1;
    localparam logic [1:0] ST_ROW  = 2'd2;

    logic                    adv;
    logic [1:0]              r_state, n_state;
    cpcr_pkg::t_cmd          r_cmd, n_cmd;
    logic [1:0]              r_kind, n_kind;
    logic [cpcr_pkg::PAIR_W-1:0] r_pair, n_pair;
    logic [cpcr_pkg::DIM_W-1:0]  r_dim, n_dim;
    logic [CNT_W-1:0]        r_pos, n_pos;
    logic [MAX_COLORS-1:0]   r_cvld, n_cvld;
    logic [CNT_W-1:0]        r_cnt_mem [MAX_COLORS];

    logic [cpcr_pkg::NPAIR_W-1:0] md, mr, pair_nx;
    logic [1:0]              first_kind;
    logic                    iss_vld;
    logic [31:0]             colsel;
    logic [cpcr_pkg::COLOR_W-1:0] iss_ca, iss_cb;
    logic [cpcr_pkg::WGT_W-1:0]   iss_wa, iss_wb, iss_d;
    logic [CIDX_W-1:0]       ra, rb, wa;
    logic [CNT_W-1:0]        cur, wd;
    logic                    wr_en;

    logic                    r_a_vld;
    logic [1:0]              r_a_kind;
    logic [cpcr_pkg::DIM_W-1:0] r_a_dim;
    logic [CNT_W-1:0]        r_a_row;
    logic                    r_a_last;
    logic [cpcr_pkg::WGT_W-1:0] r_a_wa, r_a_wb, r_a_d;
    logic                    r_a_oka, r_a_okb;
    logic [CNT_W-1:0]        r_rda, r_rdb;

    logic                    r_b_vld;
    logic [1:0]              r_b_kind;
    logic [cpcr_pkg::DIM_W-1:0] r_b_dim;
    logic [CNT_W-1:0]        r_b_row;
    logic                    r_b_last;
    logic [cpcr_pkg::PROD_W-1:0] r_b_pa, r_b_pb;
    logic [cpcr_pkg::WGT_W-1:0]  r_b_d;

    logic                    r_c_vld;
    logic [1:0]              r_c_kind;
    logic [cpcr_pkg::DIM_W-1:0] r_c_dim;
    logic [CNT_W-1:0]        r_c_row;
    logic                    r_c_last;
    logic [cpcr_pkg::PROD_W-1:0] r_c_pa, r_c_pb;
    logic [cpcr_pkg::PBD_W-1:0]  r_c_pbd;

    logic [CNT_W-1:0]        cnt_a, cnt_b;
    logic [VAL_W-1:0]        pa16, pb16, pbd52, val;

    logic                    r_out_vld;
    logic [CNT_W-1:0]        r_out_row;
    logic [cpcr_pkg::DIM_W-1:0] r_out_dim;
    logic [VAL_W-1:0]        r_out_val;
    logic                    r_out_last;

    assign adv = !r_out_vld || i_out_ready;

    assign md = (i_cfg.pair_counts[3:0] > 4'(cpcr_pkg::MAX_PAIRS))
              ? cpcr_pkg::NPAIR_W'(cpcr_pkg::MAX_PAIRS) : i_cfg.pair_counts[2:0];
    assign mr = (i_cfg.pair_counts[6:4] > 3'(cpcr_pkg::MAX_PAIRS))
              ? cpcr_pkg::NPAIR_W'(cpcr_pkg::MAX_PAIRS) : i_cfg.pair_counts[6:4];
    assign first_kind = (md != '0) ? cpcr_pkg::KIND_DIFF
                      : (mr != '0) ? cpcr_pkg::KIND_RAT_LO : cpcr_pkg::KIND_POS;
    assign pair_nx = {1'b0, r_pair} + 1'b1;

    always_comb begin
        colsel = (r_kind == cpcr_pkg::KIND_DIFF) ? i_cfg.diff_colors : i_cfg.ratio_colors;
        iss_ca = colsel[8*r_pair +: cpcr_pkg::COLOR_W];
        iss_cb = colsel[8*r_pair+4 +: cpcr_pkg::COLOR_W];
        if (r_kind == cpcr_pkg::KIND_DIFF) begin
            iss_wa = i_cfg.diff_weights_a[16*r_pair +: cpcr_pkg::WGT_W];
            iss_wb = i_cfg.diff_weights_b[16*r_pair +: cpcr_pkg::WGT_W];
        end else begin
            iss_wa = i_cfg.ratio_weights_a[16*r_pair +: cpcr_pkg::WGT_W];
            iss_wb = i_cfg.ratio_weights_b[16*r_pair +: cpcr_pkg::WGT_W];
        end
        iss_d = i_cfg.ratio_deltas[16*r_pair +: cpcr_pkg::WGT_W];
    end

    assign ra  = (r_state == ST_IDLE) ? i_q_cmd.color[CIDX_W-1:0] : iss_ca[CIDX_W-1:0];
    assign rb  = iss_cb[CIDX_W-1:0];
    assign wa  = r_cmd.color[CIDX_W-1:0];
    assign cur = r_cvld[wa] ? r_rda : '0;
    assign wd  = cur + 1'b1;

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_kind  = r_kind;
        n_pair  = r_pair;
        n_dim   = r_dim;
        n_pos   = r_pos;
        n_cvld  = r_cvld;
        o_q_pop = 1'b0;
        wr_en   = 1'b0;
        iss_vld = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (adv && i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    n_state = ST_UPD;
                    if (i_q_cmd.clr) begin
                        n_cvld = '0;
                        n_pos  = '0;
                    end
                end
            end
            ST_UPD: begin
                if (adv) begin
                    if (!r_cmd.clr) begin
                        if (r_cmd.cnt && cur < CNT_W'(MAX_POINTS)) begin
                            wr_en      = 1'b1;
                            n_cvld[wa] = 1'b1;
                        end
                        if (r_pos < CNT_W'(MAX_POINTS)) begin
                            n_pos = r_pos + 1'b1;
                        end
                    end
                    n_kind  = first_kind;
                    n_pair  = '0;
                    n_dim   = '0;
                    n_state = ST_ROW;
                end
            end
            ST_ROW: begin
                if (adv) begin
                    iss_vld = 1'b1;
                    n_dim   = r_dim + 1'b1;
                    case (r_kind)
                        cpcr_pkg::KIND_DIFF: begin
                            if (pair_nx < md) begin
                                n_pair = r_pair + 1'b1;
                            end else begin
                                n_pair = '0;
                                n_kind = (mr != '0) ? cpcr_pkg::KIND_RAT_LO
                                                    : cpcr_pkg::KIND_POS;
                            end
                        end
                        cpcr_pkg::KIND_RAT_LO: begin
                            n_kind = cpcr_pkg::KIND_RAT_HI;
                        end
                        cpcr_pkg::KIND_RAT_HI: begin
                            if (pair_nx < mr) begin
                                n_pair = r_pair + 1'b1;
                                n_kind = cpcr_pkg::KIND_RAT_LO;
                            end else begin
                                n_kind = cpcr_pkg::KIND_POS;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_kind  <= cpcr_pkg::KIND_POS;
            r_pair  <= '0;
            r_dim   <= '0;
            r_pos   <= '0;
            r_cvld  <= '0;
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_pair  <= n_pair;
            r_dim   <= n_dim;
            r_pos   <= n_pos;
            r_cvld  <= n_cvld;
            if (adv) begin
                r_a_vld   <= iss_vld;
                r_b_vld   <= r_a_vld;
                r_c_vld   <= r_b_vld;
                r_out_vld <= r_c_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_cnt_mem[wa] <= wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rda <= r_cnt_mem[ra];
            r_rdb <= r_cnt_mem[rb];
        end
    end

    assign cnt_a = r_a_oka ? r_rda : '0;
    assign cnt_b = r_a_okb ? r_rdb : '0;

    assign pa16  = VAL_W'(r_c_pa) << 16;
    assign pb16  = VAL_W'(r_c_pb) << 16;
    assign pbd52 = VAL_W'(r_c_pbd);

    always_comb begin
        case (r_c_kind)
            cpcr_pkg::KIND_DIFF:   val = pa16 - pb16;
            cpcr_pkg::KIND_RAT_LO: val = pa16 - pb16 - pbd52;
            cpcr_pkg::KIND_RAT_HI: val = pb16 - pbd52 - pa16;
            default:               val = VAL_W'(r_c_row) << 24;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_kind <= r_kind;
            r_a_dim  <= r_dim;
            r_a_row  <= r_pos;
            r_a_last <= (r_kind == cpcr_pkg::KIND_POS);
            r_a_wa   <= iss_wa;
            r_a_wb   <= iss_wb;
            r_a_d    <= iss_d;
            r_a_oka  <= cpcr_pkg::color_counted(iss_ca, MAX_COLORS) && r_cvld[ra];
            r_a_okb  <= cpcr_pkg::color_counted(iss_cb, MAX_COLORS) && r_cvld[rb];

            r_b_kind <= r_a_kind;
            r_b_dim  <= r_a_dim;
            r_b_row  <= r_a_row;
            r_b_last <= r_a_last;
            r_b_pa   <= r_a_wa * cnt_a;
            r_b_pb   <= r_a_wb * cnt_b;
            r_b_d    <= r_a_d;

            r_c_kind <= r_b_kind;
            r_c_dim  <= r_b_dim;
            r_c_row  <= r_b_row;
            r_c_last <= r_b_last;
            r_c_pa   <= r_b_pa;
            r_c_pb   <= r_b_pb;
            r_c_pbd  <= r_b_pb * r_b_d;

            r_out_row  <= r_c_row;
            r_out_dim  <= r_c_dim;
            r_out_val  <= val;
            r_out_last <= r_c_last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_row   = r_out_row;
    assign o_out_dim   = r_out_dim;
    assign o_out_value = signed'(r_out_val);
    assign o_out_last  = r_out_last;

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= CNT_W'(MAX_POINTS))
        else $error("position above saturation limit");

    a_cnt_write_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (wd <= CNT_W'(MAX_POINTS) && r_cmd.cnt && !r_cmd.clr))
        else $error("count write out of range or for wrong command");

    a_upd_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD && $past(r_state) != ST_UPD) |-> $past(o_q_pop))
        else $error("update without a popped command");

endmodule
`default_nettype wire

// File: rtl/color_prefix_constraint_rows.sv
`default_nettype none
// ----------------------------------------------------------------------------
// color_prefix_constraint_rows
// Streams point colour codes, keeps prefix counts per colour and emits one
// row of weighted constraint values per prefix position.
//
// Slave stream: tdata[3:0] colour code, tuser = start flag. A start item
// clears counts and position and yields row 0 before the row of its point.
// Master stream: one transfer per row dimension (diff pairs, then two per
// ratio pair, then the position); tlast marks the final dimension.
// Config channel: register index and data, always ready; write only while
// the block is idle.
// Row engine: per row of D = md + 2*mr + 1 dimensions it fetches a command,
// updates the counts, then issues one dimension per cycle into the shared
// multiplier pipeline (registers a, b, c, out) unless the output stalls; the
// next command is fetched after the last dimension. A start item costs two rows.
// A stalled receiver freezes the multiplier pipeline; the command queue
// keeps taking items until it fills. Reset clears counts, position,
// queue and configuration to their defaults.
// ----------------------------------------------------------------------------
module color_prefix_constraint_rows #(
    parameter int MAX_COLORS = cpcr_pkg::MAX_COLORS,
    parameter int MAX_POINTS = cpcr_pkg::MAX_POINTS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [3:0] color_code
    input  wire logic        i_s_axis_tuser,   // [0] start_req
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [79:0]      o_m_axis_tdata,   // [16:0] row_index, [20:17] dim_index,
                                               // [72:21] value
    output logic             o_m_axis_tlast,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [cpcr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [cpcr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    cpcr_pkg::t_cfg r_cfg;
    cpcr_pkg::t_cmd f_cmd;
    cpcr_pkg::t_cmd q_cmd;
    logic           f_push;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;
    logic [cpcr_pkg::CNT_W-1:0]          out_row;
    logic [cpcr_pkg::DIM_W-1:0]          out_dim;
    logic signed [cpcr_pkg::VALUE_W-1:0] out_value;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pair_counts     <= '0;
            r_cfg.diff_colors     <= '1;
            r_cfg.diff_weights_a  <= '0;
            r_cfg.diff_weights_b  <= '0;
            r_cfg.ratio_colors    <= '1;
            r_cfg.ratio_weights_a <= '0;
            r_cfg.ratio_weights_b <= '0;
            r_cfg.ratio_deltas    <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                cpcr_pkg::REG_PAIR_COUNTS:     r_cfg.pair_counts     <= i_cfg_data[6:0];
                cpcr_pkg::REG_DIFF_COLORS:     r_cfg.diff_colors     <= i_cfg_data[31:0];
                cpcr_pkg::REG_DIFF_WEIGHTS_A:  r_cfg.diff_weights_a  <= i_cfg_data;
                cpcr_pkg::REG_DIFF_WEIGHTS_B:  r_cfg.diff_weights_b  <= i_cfg_data;
                cpcr_pkg::REG_RATIO_COLORS:    r_cfg.ratio_colors    <= i_cfg_data[31:0];
                cpcr_pkg::REG_RATIO_WEIGHTS_A: r_cfg.ratio_weights_a <= i_cfg_data;
                cpcr_pkg::REG_RATIO_WEIGHTS_B: r_cfg.ratio_weights_b <= i_cfg_data;
                cpcr_pkg::REG_RATIO_DELTAS:    r_cfg.ratio_deltas    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    cpcr_front #(
        .MAX_COLORS (MAX_COLORS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_color (i_s_axis_tdata[3:0]),
        .i_start (i_s_axis_tuser),
        .i_full  (q_full),
        .o_push  (f_push),
        .o_cmd   (f_cmd)
    );

    cpcr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    cpcr_back #(
        .MAX_COLORS (MAX_COLORS),
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_row   (out_row),
        .o_out_dim   (out_dim),
        .o_out_value (out_value),
        .o_out_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {7'd0, out_value, out_dim, out_row};

endmodule
`default_nettype wire

// File: sim/cpcr_row_checker.sv
// ----------------------------------------------------------------------------
// cpcr_row_checker
// Watches the point stream, the row stream and the register channel of the
// prefix colour-count row block. Keeps its own copy of the registers, the
// per-colour prefix counts and the position, builds the rows that each point
// transfer must produce and compares every row transfer, field by field,
// with the oldest row dimension still due.
// ----------------------------------------------------------------------------
module cpcr_row_checker
    import cpcr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [7:0]            i_s_tdata,   // [3:0] color_code
    input  logic                  i_s_tuser,   // [0] start_req
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [79:0]           i_m_tdata,   // [16:0] row_index, [20:17] dim_index,
                                               // [72:21] value
    input  logic                  i_m_tlast,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending
);

    typedef struct packed {
        logic [CNT_W-1:0]   row;
        logic [DIM_W-1:0]   dim;
        logic [VALUE_W-1:0] value;
        logic               last;
    } t_row_dim;

    t_cfg             regs;
    logic [CNT_W-1:0] color_counts [MAX_COLORS];
    logic [CNT_W-1:0] prefix_pos;
    t_row_dim         dims_due [$];
    int               mismatches = 0;

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t row check: %s got 0x%0h, want 0x%0h", $time, field, got, want);
        mismatches++;
    endtask

    function automatic logic [63:0] pair_count(input logic [31:0] colors, input int k,
                                               input int side);
        logic [COLOR_W-1:0] c;
        c = colors[8*k + 4*side +: 4];
        if (c == COLOR_NONE || c >= MAX_COLORS)
            return 64'd0;
        return 64'(color_counts[c]);
    endfunction

    task automatic add_dim(input int dim, input logic [63:0] v, input logic last);
        t_row_dim r;
        r.row   = prefix_pos;
        r.dim   = dim[DIM_W-1:0];
        r.value = v[VALUE_W-1:0];
        r.last  = last;
        dims_due = {dims_due, r};
    endtask

    task automatic queue_row();
        int          md;
        int          mr;
        int          dim;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] d;
        md  = int'(regs.pair_counts[3:0]);
        mr  = int'(regs.pair_counts[6:4]);
        dim = 0;
        if (md > MAX_PAIRS) md = MAX_PAIRS;
        if (mr > MAX_PAIRS) mr = MAX_PAIRS;
        for (int k = 0; k < md; k++) begin
            a = 64'(regs.diff_weights_a[16*k +: 16]) * pair_count(regs.diff_colors, k, 0);
            b = 64'(regs.diff_weights_b[16*k +: 16]) * pair_count(regs.diff_colors, k, 1);
            add_dim(dim, (a << 16) - (b << 16), 1'b0);
            dim++;
        end
        for (int k = 0; k < mr; k++) begin
            a = 64'(regs.ratio_weights_a[16*k +: 16]) * pair_count(regs.ratio_colors, k, 0);
            b = 64'(regs.ratio_weights_b[16*k +: 16]) * pair_count(regs.ratio_colors, k, 1);
            d = 64'(regs.ratio_deltas[16*k +: 16]);
            add_dim(dim, (a << 16) - b * (64'd65536 + d), 1'b0);
            dim++;
            add_dim(dim, b * (64'd65536 - d) - (a << 16), 1'b0);
            dim++;
        end
        add_dim(dim, 64'(prefix_pos) << 24, 1'b1);
    endtask

    always @(posedge i_clk) begin : watch
        t_row_dim           want;
        logic [COLOR_W-1:0] c;
        if (!i_rst_n) begin
            regs.pair_counts     = '0;
            regs.diff_colors     = '1;
            regs.diff_weights_a  = '0;
            regs.diff_weights_b  = '0;
            regs.ratio_colors    = '1;
            regs.ratio_weights_a = '0;
            regs.ratio_weights_b = '0;
            regs.ratio_deltas    = '0;
            for (int i = 0; i < MAX_COLORS; i++) color_counts[i] = '0;
            prefix_pos = '0;
            dims_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_PAIR_COUNTS:     regs.pair_counts     = i_cfg_data[6:0];
                    REG_DIFF_COLORS:     regs.diff_colors     = i_cfg_data[31:0];
                    REG_DIFF_WEIGHTS_A:  regs.diff_weights_a  = i_cfg_data;
                    REG_DIFF_WEIGHTS_B:  regs.diff_weights_b  = i_cfg_data;
                    REG_RATIO_COLORS:    regs.ratio_colors    = i_cfg_data[31:0];
                    REG_RATIO_WEIGHTS_A: regs.ratio_weights_a = i_cfg_data;
                    REG_RATIO_WEIGHTS_B: regs.ratio_weights_b = i_cfg_data;
                    REG_RATIO_DELTAS:    regs.ratio_deltas    = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                c = i_s_tdata[COLOR_W-1:0];
                if (i_s_tuser) begin
                    for (int i = 0; i < MAX_COLORS; i++) color_counts[i] = '0;
                    prefix_pos = '0;
                    queue_row();
                end
                if (c != COLOR_NONE && c < MAX_COLORS && color_counts[c] < MAX_POINTS)
                    color_counts[c] = color_counts[c] + 1'b1;
                if (prefix_pos < MAX_POINTS)
                    prefix_pos = prefix_pos + 1'b1;
                queue_row();
            end
            if (i_m_tvalid && i_m_tready) begin
                if (dims_due.size() == 0) begin
                    report_mismatch("unexpected transfer", 64'(i_m_tdata), 64'd0);
                end else begin
                    want = dims_due.pop_front();
                    if (i_m_tdata[16:0] !== want.row)
                        report_mismatch("row_index", 64'(i_m_tdata[16:0]), 64'(want.row));
                    if (i_m_tdata[20:17] !== want.dim)
                        report_mismatch("dim_index", 64'(i_m_tdata[20:17]), 64'(want.dim));
                    if (i_m_tdata[72:21] !== want.value)
                        report_mismatch("value", 64'(i_m_tdata[72:21]), 64'(want.value));
                    if (i_m_tlast !== want.last)
                        report_mismatch("tlast", 64'(i_m_tlast), 64'(want.last));
                end
            end
        end
        o_pending <= dims_due.size();
        o_errors  <= mismatches;
    end

endmodule

// File: sim/color_prefix_constraint_rows_tb.sv
// ----------------------------------------------------------------------------
// color_prefix_constraint_rows_tb
// Drives point colour codes into the prefix colour-count row block under a
// series of register settings: points ahead of any start, a directed sweep
// of all colours and start cases, and randomized runs under four idling
// mixes with one long receiver hold-off. A side checker predicts and
// compares every row transfer.
// ----------------------------------------------------------------------------
module color_prefix_constraint_rows_tb;
    import cpcr_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [7:0]            i_s_axis_tdata;
    logic                  i_s_axis_tuser;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [79:0]           o_m_axis_tdata;
    logic                  o_m_axis_tlast;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int   mismatch_total;
    int   dims_outstanding;
    int   tx_idle_pct  = 0;
    int   rx_stall_pct = 0;
    logic hold_req     = 1'b0;
    logic rx_hold      = 1'b0;

    color_prefix_constraint_rows DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    cpcr_row_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_axis_tvalid),
        .i_s_tready  (o_s_axis_tready),
        .i_s_tdata   (i_s_axis_tdata),
        .i_s_tuser   (i_s_axis_tuser),
        .i_m_tvalid  (o_m_axis_tvalid),
        .i_m_tready  (i_m_axis_tready),
        .i_m_tdata   (o_m_axis_tdata),
        .i_m_tlast   (o_m_axis_tlast),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (mismatch_total),
        .o_pending   (dims_outstanding)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #20000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    initial begin
        wait (hold_req);
        rx_hold <= 1'b1;
        repeat (400) @(negedge i_clk);
        rx_hold <= 1'b0;
    end

    task automatic send_point(input logic [COLOR_W-1:0] color, input logic start);
        while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'h0, color};
        i_s_axis_tuser  <= start;
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic program_regs(input t_cfg c);
        logic [CFG_IDX_W-1:0]  sel;
        logic [CFG_DATA_W-1:0] val;
        i_s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (dims_outstanding != 0) @(negedge i_clk);
        for (int k = 0; k < 8; k++) begin
            sel = k[CFG_IDX_W-1:0];
            case (sel)
                REG_PAIR_COUNTS:     val = 64'(c.pair_counts);
                REG_DIFF_COLORS:     val = 64'(c.diff_colors);
                REG_DIFF_WEIGHTS_A:  val = c.diff_weights_a;
                REG_DIFF_WEIGHTS_B:  val = c.diff_weights_b;
                REG_RATIO_COLORS:    val = 64'(c.ratio_colors);
                REG_RATIO_WEIGHTS_A: val = c.ratio_weights_a;
                REG_RATIO_WEIGHTS_B: val = c.ratio_weights_b;
                default:             val = c.ratio_deltas;
            endcase
            i_cfg_valid <= 1'b1;
            i_cfg_index <= sel;
            i_cfg_data  <= val;
            do @(posedge i_clk); while (!o_cfg_ready);
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] random_colors();
        logic [31:0] v;
        for (int n = 0; n < 8; n++)
            v[4*n +: 4] = ($urandom_range(4) == 0) ? COLOR_NONE : 4'($urandom_range(14));
        return v;
    endfunction

    function automatic logic [63:0] random_fields16();
        logic [63:0] v;
        for (int n = 0; n < 4; n++) begin
            case ($urandom_range(5))
                0:       v[16*n +: 16] = 16'h0000;
                1:       v[16*n +: 16] = 16'hFFFF;
                default: v[16*n +: 16] = 16'($urandom);
            endcase
        end
        return v;
    endfunction

    initial begin : stimulus
        t_cfg cfg;
        logic start;
        logic [COLOR_W-1:0] color;

        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // points ahead of any start run on the reset state
        send_point(4'd0, 1'b0);
        send_point(COLOR_NONE, 1'b0);
        send_point(4'd7, 1'b0);

        cfg.pair_counts     = 7'h44;
        cfg.diff_colors     = 32'h0FE1_3210;
        cfg.diff_weights_a  = 64'hFFFF_0001_8000_FFFF;
        cfg.diff_weights_b  = 64'h0000_FFFF_0100_FFFF;
        cfg.ratio_colors    = 32'hF50E_4321;
        cfg.ratio_weights_a = 64'hFFFF_0100_0000_FFFF;
        cfg.ratio_weights_b = 64'h0100_FFFF_FFFF_FFFF;
        cfg.ratio_deltas    = 64'hFFFF_0000_8000_0001;
        program_regs(cfg);

        send_point(4'd0, 1'b1);
        for (int c = 0; c < 16; c++) send_point(4'(c), 1'b0);
        send_point(COLOR_NONE, 1'b1);
        send_point(4'd3, 1'b1);
        send_point(4'd14, 1'b0);

        for (int phase = 0; phase < 4; phase++) begin
            cfg.diff_colors     = random_colors();
            cfg.diff_weights_a  = random_fields16();
            cfg.diff_weights_b  = random_fields16();
            cfg.ratio_colors    = random_colors();
            cfg.ratio_weights_a = random_fields16();
            cfg.ratio_weights_b = random_fields16();
            cfg.ratio_deltas    = random_fields16();
            case (phase)
                0: begin
                    cfg.pair_counts = 7'h44;
                    tx_idle_pct = 0;  rx_stall_pct = 0;
                end
                1: begin
                    cfg.pair_counts = 7'h7F;
                    tx_idle_pct = 73; rx_stall_pct = 0;
                end
                2: begin
                    cfg.pair_counts = 7'h00;
                    tx_idle_pct = 0;  rx_stall_pct = 73;
                end
                default: begin
                    cfg.pair_counts = 7'($urandom_range(127));
                    tx_idle_pct = 17; rx_stall_pct = 17;
                end
            endcase
            program_regs(cfg);
            if (phase == 0) hold_req = 1'b1;
            for (int n = 0; n < 89; n++) begin
                start = (n == 0) || ($urandom_range(99) < 6);
                color = ($urandom_range(9) == 0) ? COLOR_NONE : 4'($urandom_range(14));
                send_point(color, start);
            end
        end
        i_s_axis_tvalid <= 1'b0;

        while (dims_outstanding != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_total == 0 && dims_outstanding == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
